/* src/ppst_pkg.sv */
// ----------------------------------------------------------------------------
// ppst_pkg
// shared types, register codes and the arctangent table of the steering block
// ----------------------------------------------------------------------------
package ppst_pkg;

  localparam int CORD_W   = 48;
  localparam int ANG_W    = 34;
  localparam int TAB_LEN  = 24;
  localparam int STEP_W   = 5;

  localparam logic [1:0] REG_LOOKAHEAD = 2'd0;
  localparam logic [1:0] REG_BAND      = 2'd1;
  localparam logic [1:0] REG_SPEED     = 2'd2;

  localparam logic [14:0] LOOKAHEAD_RST = 15'd179;
  localparam logic [14:0] BAND_RST      = 15'd51;
  localparam logic [14:0] SPEED_RST     = 15'd102;
  localparam logic [16:0] GAIN_Q16      = 17'd107921;

  typedef struct packed {
    logic start;
    logic vec;
  } cord_cmd_t;

  function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic [31:0] v;
    v = 32'h0;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

/* src/ppst_ram.sv */
// ----------------------------------------------------------------------------
// ppst_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module ppst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/ppst_cordic.sv */
// ----------------------------------------------------------------------------
// ppst_cordic
// iterative cordic, one micro-rotation per cycle, rotation and vectoring modes
// ----------------------------------------------------------------------------
module ppst_cordic #(
  parameter int ANGLE_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ppst_pkg::cord_cmd_t                 cmd,
  input  logic signed [ppst_pkg::CORD_W-1:0]  x_in,
  input  logic signed [ppst_pkg::CORD_W-1:0]  y_in,
  input  logic signed [ppst_pkg::ANG_W-1:0]   z_in,
  output logic                                busy,
  output logic                                done,
  output logic signed [ppst_pkg::CORD_W-1:0]  x_out,
  output logic signed [ppst_pkg::CORD_W-1:0]  y_out,
  output logic signed [ppst_pkg::ANG_W-1:0]   z_out
);

  localparam int NSTEP = (ANGLE_STEPS < ppst_pkg::TAB_LEN) ? ANGLE_STEPS : ppst_pkg::TAB_LEN;
  localparam logic [ppst_pkg::STEP_W-1:0] LAST = ppst_pkg::STEP_W'(NSTEP - 1);

  logic signed [ppst_pkg::CORD_W-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [ppst_pkg::ANG_W-1:0]  z_r, z_nxt, tab;
  logic [ppst_pkg::STEP_W-1:0]        cnt_r;
  logic                               busy_r, done_r, vec_r, sel;

  always_comb begin
    xs    = x_r >>> cnt_r;
    ys    = y_r >>> cnt_r;
    tab   = ppst_pkg::ANG_W'(ppst_pkg::atan_entry(cnt_r));
    sel   = vec_r ? y_r[ppst_pkg::CORD_W-1] : !z_r[ppst_pkg::ANG_W-1];
    if (sel) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - tab;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + tab;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start && !busy_r) begin
      x_r   <= x_in;
      y_r   <= y_in;
      z_r   <= z_in;
      vec_r <= cmd.vec;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign busy  = busy_r;
  assign done  = done_r;
  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule

/* src/pure_pursuit_steering_top.sv */
// ----------------------------------------------------------------------------
// pure_pursuit_steering_top
// pure pursuit steering: waypoint table in ram, sequential lookahead scan
// ----------------------------------------------------------------------------
// usage:
//   pulse start with the item fields while busy is low. mode 0 stores one
//   waypoint (first_point restarts the path, points past the table
//   capacity are dropped). mode 1 runs a pose query. a pose query passes
//   a setup state, then scans the table from entry 0; each entry passes
//   the states ram read, difference, squares and band test. a band hit
//   adds a frame rotation on the shared cordic and, if the point is ahead,
//   a steering vectoring pass that ends the scan.
//   the result shows for one cycle with out_valid and cannot be held off;
//   busy drops in that same cycle. a query on an empty path gives nothing.
//   configuration writes go through cfg_valid/cfg_ready, cfg_ready is always
//   high. reset empties the path and loads the default registers; the ram
//   needs no clearing since only stored entries are scanned.
// ----------------------------------------------------------------------------
module pure_pursuit_steering_top #(
  parameter int PATH_DEPTH  = 1024,
  parameter int ANGLE_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_mode,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [15:0]        in_heading,
  input  logic               in_first_point,
  output logic               out_valid,
  output logic               out_found,
  output logic signed [15:0] out_target_x,
  output logic signed [15:0] out_target_y,
  output logic signed [15:0] out_steering,
  output logic [14:0]        out_speed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int AW = $clog2(PATH_DEPTH);
  localparam int CW = AW + 1;
  localparam int DW = ppst_pkg::CORD_W;
  localparam int ZW = ppst_pkg::ANG_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_DIFF = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_TEST = 4'd5;
  localparam logic [3:0] S_ROT  = 4'd6;
  localparam logic [3:0] S_VEC  = 4'd7;

  logic [3:0]  state_r, state_nxt;
  logic [14:0] la_r, band_r, speed_r;
  logic [CW-1:0] count_r;
  logic [AW-1:0] idx_r;
  logic signed [15:0] px_r, py_r, ptx_r, pty_r;
  logic [15:0] head_r;
  logic signed [16:0] dx_r, dy_r, lo;
  logic [33:0] sqx_r, sqy_r, lo2_r, hi2_r, d2;
  logic        lo_neg_r;
  logic [39:0] lak_r;
  logic        out_valid_r, found_r;
  logic signed [15:0] tx_r, ty_r, st_r;

  // load path
  logic          load_acc, pose_acc, ram_we;
  logic [CW-1:0] waddr_full;
  logic [31:0]   rdata;

  // cordic
  ppst_pkg::cord_cmd_t cmd;
  logic signed [DW-1:0] cx_in, cy_in, cx_out, cy_out;
  logic signed [ZW-1:0] cz_in, cz_out;
  logic        cord_busy, cord_done;
  logic [15:0] neg_head;
  logic signed [31:0] ang;
  logic        pre_rot;
  logic signed [DW-1:0] xc0, yc0;
  logic        last_entry, pass;
  logic signed [ZW-1:0] zr;
  logic signed [17:0] st_full;
  logic [31:0] lak_prod;

  assign load_acc   = start && !busy && !in_mode;
  assign pose_acc   = start && !busy && in_mode;
  assign waddr_full = in_first_point ? '0 : count_r;
  assign ram_we     = load_acc && (waddr_full < CW'(PATH_DEPTH));

  ppst_ram #(.WIDTH(32), .DEPTH(PATH_DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr_full[AW-1:0]),
    .wdata({in_pos_x, in_pos_y}),
    .re   (state_r == S_RD),
    .raddr(idx_r),
    .rdata(rdata)
  );

  ppst_cordic #(.ANGLE_STEPS(ANGLE_STEPS)) u_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .x_in (cx_in),
    .y_in (cy_in),
    .z_in (cz_in),
    .busy (cord_busy),
    .done (cord_done),
    .x_out(cx_out),
    .y_out(cy_out),
    .z_out(cz_out)
  );

  // config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      la_r    <= ppst_pkg::LOOKAHEAD_RST;
      band_r  <= ppst_pkg::BAND_RST;
      speed_r <= ppst_pkg::SPEED_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ppst_pkg::REG_LOOKAHEAD: la_r    <= cfg_data[14:0];
        ppst_pkg::REG_BAND:      band_r  <= cfg_data[14:0];
        ppst_pkg::REG_SPEED:     speed_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // path count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (load_acc) begin
      if (ram_we) begin
        count_r <= waddr_full + 1'b1;
      end
    end
  end

  // datapath helpers
  assign lo         = $signed({2'b00, la_r}) - $signed({2'b00, band_r});
  assign d2         = sqx_r + sqy_r;
  assign pass       = (lo_neg_r || (d2 > lo2_r)) && (d2 < hi2_r);
  assign last_entry = ({1'b0, idx_r} + 1'b1) == count_r;
  assign neg_head   = 16'(17'h10000 - {1'b0, head_r});
  assign ang        = $signed({neg_head, 16'h0000});
  assign pre_rot    = (ang > 32'sd1073741824) || (ang < -32'sd1073741824);
  assign xc0        = DW'(dx_r) <<< 8;
  assign yc0        = DW'(dy_r) <<< 8;
  assign zr         = cz_out + ZW'(32768);
  assign st_full    = 18'(zr >>> 16);
  assign lak_prod   = {17'd0, la_r} * {15'd0, ppst_pkg::GAIN_Q16};

  always_comb begin
    cmd   = '0;
    cx_in = xc0;
    cy_in = yc0;
    cz_in = ZW'(ang);
    if (state_r == S_TEST && pass) begin
      cmd.start = 1'b1;
      if (pre_rot) begin
        cx_in = -xc0;
        cy_in = -yc0;
        cz_in = ZW'($signed({~ang[31], ang[30:0]}));
      end
    end else if (state_r == S_ROT && cord_done && cx_out > 0) begin
      cmd.start = 1'b1;
      cmd.vec   = 1'b1;
      cx_in     = DW'(lak_r);
      cy_in     = cy_out <<< 17;
      cz_in     = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (pose_acc && count_r != '0) state_nxt = S_PREP;
      S_PREP: state_nxt = S_RD;
      S_RD:   state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_SQ;
      S_SQ:   state_nxt = S_TEST;
      S_TEST: begin
        if (pass) state_nxt = S_ROT;
        else if (last_entry) state_nxt = S_IDLE;
        else state_nxt = S_RD;
      end
      S_ROT: begin
        if (cord_done) begin
          if (cx_out > 0) state_nxt = S_VEC;
          else if (last_entry) state_nxt = S_IDLE;
          else state_nxt = S_RD;
        end
      end
      S_VEC: if (cord_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (state_r == S_PREP) begin
        idx_r <= '0;
      end
      if ((state_r == S_TEST && !pass) || (state_r == S_ROT && cord_done && !(cx_out > 0))) begin
        if (last_entry) out_valid_r <= 1'b1;
        else idx_r <= idx_r + 1'b1;
      end
      if (state_r == S_VEC && cord_done) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pose_acc) begin
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
      head_r <= in_heading;
    end
    if (state_r == S_PREP) begin
      lo_neg_r <= lo[16];
      lo2_r    <= 34'(lo) * 34'(lo);
      hi2_r    <= 34'({17'd0, la_r + 16'd0 + {1'b0, band_r}} * {17'd0, {1'b0, la_r} + {1'b0, band_r}});
      lak_r    <= {lak_prod, 8'h00};
      found_r  <= 1'b0;
      tx_r     <= px_r;
      ty_r     <= py_r;
      st_r     <= '0;
    end
    if (state_r == S_DIFF) begin
      ptx_r <= rdata[31:16];
      pty_r <= rdata[15:0];
      dx_r  <= 17'($signed(rdata[31:16])) - 17'(px_r);
      dy_r  <= 17'($signed(rdata[15:0])) - 17'(py_r);
    end
    if (state_r == S_SQ) begin
      sqx_r <= 34'(dx_r) * 34'(dx_r);
      sqy_r <= 34'(dy_r) * 34'(dy_r);
    end
    if (state_r == S_VEC && cord_done) begin
      found_r <= 1'b1;
      tx_r    <= ptx_r;
      ty_r    <= pty_r;
      if (st_full > 18'sd16384) st_r <= 16'sd16384;
      else if (st_full < -18'sd16384) st_r <= -16'sd16384;
      else st_r <= st_full[15:0];
    end
  end

  assign busy         = state_r != S_IDLE;
  assign out_valid    = out_valid_r;
  assign out_found    = found_r;
  assign out_target_x = tx_r;
  assign out_target_y = ty_r;
  assign out_steering = st_r;
  assign out_speed    = speed_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(PATH_DEPTH)) else $error("path count past capacity");
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than a cycle");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while still scanning");
  a_cord_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !cord_busy) else $error("cordic started while running");

endmodule

/* verif/pure_pursuit_steering_top_tb.sv */
// ----------------------------------------------------------------------------
// pure_pursuit_steering_top_tb
// self-checking bench: directed table, then random sessions of path loads
// and pose queries under several register settings.
// every result is compared field by field with a cordic-level predictor or,
// for hand-marked directed rows, with the fields given in the row
`timescale 1ns / 1ps

module pure_pursuit_steering_top_tb;

  localparam int DEPTH = 1024;
  localparam int STEPS = 16;
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_POSE = 1'b1;
  localparam longint QUARTER = 64'sd1073741824;

  typedef struct packed {
    logic        mode;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] hd;
    logic        fp;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] tx;
    logic [15:0] ty;
    logic [15:0] st;
    logic [14:0] spd;
  } cmd_t;

  typedef struct packed {
    item_t it;
    logic  hand;
    cmd_t  want;
  } row_t;

  logic clk, rst_n, start, busy;
  logic in_mode, in_first_point;
  logic signed [15:0] in_pos_x, in_pos_y;
  logic [15:0] in_heading;
  logic out_valid, out_found;
  logic signed [15:0] out_target_x, out_target_y, out_steering;
  logic [14:0] out_speed;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  pure_pursuit_steering_top dut (.*);

  logic signed [15:0] wp_x [0:DEPTH-1];
  logic signed [15:0] wp_y [0:DEPTH-1];
  int wp_count;
  longint la_m, band_m, spd_m;
  cmd_t cmd_q[$];
  int errors, n_cmds, n_items, n_found;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint s32(logic [31:0] u);
    return u[31] ? longint'(u) - 64'sd4294967296 : longint'(u);
  endfunction

  function automatic longint step_angle(int i);
    case (i)
      0: return 64'h20000000;   1: return 64'h12E4051D;
      2: return 64'h09FB385B;   3: return 64'h051111D4;
      4: return 64'h028B0D43;   5: return 64'h0145D7E1;
      6: return 64'h00A2F61E;   7: return 64'h00517C55;
      8: return 64'h0028BE53;   9: return 64'h00145F2E;
      10: return 64'h000A2F98;  11: return 64'h000517CC;
      12: return 64'h00028BE6;  13: return 64'h000145F3;
      14: return 64'h0000A2F9;  default: return 64'h0000517C;
    endcase
  endfunction

  function automatic void rotate_frame(inout longint x, inout longint y,
                                       input logic [31:0] ang);
    longint z, nx, ny;
    z = s32(ang);
    if (z > QUARTER || z < -QUARTER) begin
      x = -x;
      y = -y;
      z = s32(ang + 32'h80000000);
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= step_angle(i);
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += step_angle(i);
      end
      x = nx; y = ny;
    end
  endfunction

  function automatic longint steer_angle(longint x, longint y);
    longint z, nx, ny;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (y < 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= step_angle(i);
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += step_angle(i);
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  // updates the waypoint table, returns 1 when a steering command is due
  function automatic bit pursue(item_t it, output cmd_t c);
    longint px, py, dx, dy, d2, xc, yc, lo, hi, st;
    logic [31:0] ang;
    px = longint'($signed(it.x));
    py = longint'($signed(it.y));
    c.found = 1'b0; c.tx = it.x; c.ty = it.y; c.st = '0; c.spd = spd_m[14:0];
    if (it.mode == MODE_LOAD) begin
      if (it.fp) wp_count = 0;
      if (wp_count < DEPTH) begin
        wp_x[wp_count] = it.x;
        wp_y[wp_count] = it.y;
        wp_count++;
      end
      return 1'b0;
    end
    if (wp_count == 0) return 1'b0;
    lo = la_m - band_m;
    hi = la_m + band_m;
    ang = {16'(17'h10000 - it.hd), 16'h0};
    for (int i = 0; i < wp_count; i++) begin
      dx = longint'(wp_x[i]) - px;
      dy = longint'(wp_y[i]) - py;
      d2 = dx * dx + dy * dy;
      if (!((lo < 0 || d2 > lo * lo) && d2 < hi * hi)) continue;
      xc = dx * 256;
      yc = dy * 256;
      rotate_frame(xc, yc, ang);
      if (xc > 0) begin
        st = (steer_angle(la_m * 256 * 107921, yc * 2 * 65536) + 32768) >>> 16;
        if (st > 16384) st = 16384;
        if (st < -16384) st = -16384;
        c.found = 1'b1; c.tx = wp_x[i]; c.ty = wp_y[i]; c.st = st[15:0];
        break;
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    cmd_t w;
    if (rst_n && out_valid) begin
      if (cmd_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected steering command at %0t", $realtime);
      end else begin
        w = cmd_q.pop_front();
        n_cmds++;
        if (w.found) n_found++;
        if (out_found !== w.found || out_target_x !== w.tx || out_target_y !== w.ty ||
            out_steering !== w.st || out_speed !== w.spd) begin
          errors++;
          if (errors <= 10)
            $display("mismatch at %0t: exp f=%0d x=%0d y=%0d st=%0d sp=%0d got f=%0d x=%0d y=%0d st=%0d sp=%0d",
                     $realtime, w.found, $signed(w.tx), $signed(w.ty), $signed(w.st), w.spd,
                     out_found, out_target_x, out_target_y, out_steering, out_speed);
        end
      end
    end
  end

  task automatic send(item_t it, bit hand, cmd_t want);
    cmd_t c;
    in_mode <= it.mode; in_pos_x <= it.x; in_pos_y <= it.y;
    in_heading <= it.hd; in_first_point <= it.fp;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    n_items++;
    if (pursue(it, c)) cmd_q.insert(cmd_q.size(), hand ? want : c);
  endtask

  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    cfg_index <= idx;
    cfg_data <= {1'($urandom_range(0, 1)), val};
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ppst_pkg::REG_LOOKAHEAD: la_m = val;
      ppst_pkg::REG_BAND:      band_m = val;
      default:                 spd_m = val;
    endcase
  endtask

  task automatic setup(logic [14:0] la, logic [14:0] bd, logic [14:0] sp);
    drain();
    write_reg(ppst_pkg::REG_LOOKAHEAD, la);
    write_reg(ppst_pkg::REG_BAND, bd);
    write_reg(ppst_pkg::REG_SPEED, sp);
    @(posedge clk);
  endtask

  task automatic session(int npts, int nq);
    item_t it;
    cmd_t none;
    int cx, cy, span;
    none = '0;
    span = int'(la_m + band_m) + 40;
    if (span > 30000) span = 30000;
    cx = $urandom_range(0, 40000) - 20000;
    cy = $urandom_range(0, 40000) - 20000;
    for (int i = 0; i < npts + nq; i++) begin
      if ($urandom_range(0, 99) < 10) begin
        it = item_t'({$urandom, $urandom});
      end else if (i < npts) begin
        it.mode = MODE_LOAD;
        it.x = 16'(cx + $urandom_range(0, 2 * span) - span);
        it.y = 16'(cy + $urandom_range(0, 2 * span) - span);
        it.hd = 16'($urandom);
        it.fp = (i == 0);
      end else begin
        it.mode = MODE_POSE;
        it.x = 16'(cx + $urandom_range(0, span / 2) - span / 4);
        it.y = 16'(cy + $urandom_range(0, span / 2) - span / 4);
        it.hd = 16'($urandom);
        it.fp = 1'($urandom_range(0, 1));
      end
      send(it, 1'b0, none);
      maybe_idle();
    end
  endtask

  row_t rows [$];

  function automatic row_t mk(logic m, int x, int y, int hd, logic fp, logic h,
                              logic f, int tx, int ty);
    row_t r;
    r.it = {m, 16'(x), 16'(y), 16'(hd), fp};
    r.hand = h;
    r.want = {f, 16'(tx), 16'(ty), 16'h0, 15'd102};
    return r;
  endfunction

  initial begin
    int sess;
    errors = 0; n_cmds = 0; n_items = 0; n_found = 0; calm = 0;
    wp_count = 0; la_m = 179; band_m = 51; spd_m = 102;
    rst_n = 1'b0; start = 1'b0; in_mode = 1'b0; in_pos_x = '0; in_pos_y = '0;
    in_heading = '0; in_first_point = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pose on empty path, point at vehicle, point behind, far away, quadrants
    rows.insert(rows.size(), mk(MODE_POSE, 100, 100, 0, 1, 0, 0, 0, 0));
    rows.insert(rows.size(), mk(MODE_LOAD, 0, 0, 65535, 1, 0, 0, 0, 0));
    rows.insert(rows.size(), mk(MODE_POSE, 0, 0, 0, 0, 1, 0, 0, 0));
    rows.insert(rows.size(), mk(MODE_LOAD, 179, 0, 0, 0, 0, 0, 0, 0));
    rows.insert(rows.size(), mk(MODE_POSE, 0, 0, 0, 1, 0, 0, 0, 0));
    rows.insert(rows.size(), mk(MODE_POSE, 0, 0, 32768, 0, 1, 0, 0, 0));
    rows.insert(rows.size(), mk(MODE_LOAD, 32767, -32768, 0, 1, 0, 0, 0, 0));
    rows.insert(rows.size(), mk(MODE_POSE, -32768, 32767, 65535, 0, 1, 0, -32768, 32767));
    rows.insert(rows.size(), mk(MODE_LOAD, 0, 179, 0, 1, 0, 0, 0, 0));
    rows.insert(rows.size(), mk(MODE_POSE, 0, 0, 16384, 0, 0, 0, 0, 0));
    rows.insert(rows.size(), mk(MODE_POSE, 0, 0, 49152, 0, 1, 0, 0, 0));
    rows.insert(rows.size(), mk(MODE_LOAD, -179, 0, 0, 0, 0, 0, 0, 0));
    rows.insert(rows.size(), mk(MODE_POSE, 0, 0, 32768, 0, 0, 0, 0, 0));
    rows.insert(rows.size(), mk(MODE_LOAD, 150, -100, 0, 0, 0, 0, 0, 0));
    rows.insert(rows.size(), mk(MODE_LOAD, 120, 120, 0, 0, 0, 0, 0, 0));
    rows.insert(rows.size(), mk(MODE_POSE, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.insert(rows.size(), mk(MODE_POSE, 20, -30, 8192, 0, 0, 0, 0, 0));
    rows.insert(rows.size(), mk(MODE_POSE, -32768, -32768, 57344, 1, 0, 0, 0, 0));
    foreach (rows[i]) begin
      send(rows[i].it, rows[i].hand, rows[i].want);
      maybe_idle();
    end

    sess = 0;
    while (n_items < 580) begin
      case (sess % 6)
        0: setup(15'd179, 15'd51, 15'd102);
        1: setup(15'd1, 15'd0, 15'd0);
        2: setup(15'd32767, 15'd32767, 15'd32767);
        3: setup(15'd300, 15'd500, 15'd77);
        4: setup(15'd2000, 15'd100, 15'd5000);
        default: setup(15'($urandom_range(1, 4000)), 15'($urandom_range(0, 1500)),
                       15'($urandom));
      endcase
      calm = (sess >= 4 && sess < 8);
      if (sess == 9) drain();
      session($urandom_range(2, 30), $urandom_range(3, 15));
      sess++;
    end
    drain();

    $display("%0d items sent, %0d steering commands checked (%0d with a target found)",
             n_items, n_cmds, n_found);
    $display("covered directed edge cases, six register settings and %0d random sessions",
             sess);
    if (errors == 0 && cmd_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d commands missing", errors, cmd_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* pure_pursuit_steering_top.f */
src/ppst_pkg.sv
src/ppst_ram.sv
src/ppst_cordic.sv
src/pure_pursuit_steering_top.sv
verif/pure_pursuit_steering_top_tb.sv
